>>> design/mavf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavf_pkg: shared types and constants of the median agreement vote filter
// Field widths, register codes, controller states and command strobes.
// ----------------------------------------------------------------------------
package mavf_pkg;

	localparam int HISTORY_DEPTH_DEF = 8;

	localparam int VAL_W  = 13;
	localparam int CONF_W = 17;
	localparam int VOTE_W = 4;
	localparam int TOL_W  = 8;

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	localparam logic [VOTE_W-1:0] MIN_VOTES_RST = 4'd3;
	localparam logic [TOL_W-1:0]  TOL_FLOOR_RST = 8'd8;

	// register index, taken from byte address bit 2
	localparam logic REG_MIN_VOTES = 1'b0;
	localparam logic REG_TOL_FLOOR = 1'b1;

	typedef struct packed {
		logic              restart;
		logic [VAL_W-1:0]  detect_value;
		logic [CONF_W-1:0] detect_conf;
	} det_item_t;

	typedef struct packed {
		logic [VAL_W-1:0]  consensus_value;
		logic [CONF_W-1:0] consensus_conf;
	} res_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COUNT,
		ST_MEDIAN,
		ST_AGREE,
		ST_PREP,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;      // store the accepted detection in the ring
		logic count;     // count nonzero entries, clear accumulators
		logic med_step;  // test one median candidate
		logic agr_step;  // test one entry for agreement
		logic div_init;  // load the divider
		logic div_step;  // one quotient bit
		logic out_load;  // capture the result
	} cmd_t;

	// width of the confidence sum over a full history
	function automatic int sum_width(input int depth);
		return CONF_W + $clog2(depth + 1);
	endfunction

endpackage

>>> design/mavf_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavf_stream_if: valid/ready channel
// One transfer per rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface mavf_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> design/mavf_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavf_cfg: configuration registers
// APB-style write and read of min_votes and tol_floor.
// ----------------------------------------------------------------------------
module mavf_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mavf_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [mavf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [mavf_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output logic [mavf_pkg::VOTE_W-1:0]         min_votes,
	output logic [mavf_pkg::TOL_W-1:0]          tol_floor
);
	logic [mavf_pkg::VOTE_W-1:0] min_votes_q;
	logic [mavf_pkg::TOL_W-1:0]  tol_floor_q;
	logic                        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_votes_q <= mavf_pkg::MIN_VOTES_RST;
			tol_floor_q <= mavf_pkg::TOL_FLOOR_RST;
		end else if (wr_en) begin
			case (paddr[2])
				mavf_pkg::REG_MIN_VOTES: min_votes_q <= pwdata[mavf_pkg::VOTE_W-1:0];
				mavf_pkg::REG_TOL_FLOOR: tol_floor_q <= pwdata[mavf_pkg::TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			mavf_pkg::REG_MIN_VOTES:
				prdata = mavf_pkg::APB_DATA_W'(min_votes_q);
			mavf_pkg::REG_TOL_FLOOR:
				prdata = mavf_pkg::APB_DATA_W'(tol_floor_q);
			default:
				prdata = '0;
		endcase
	end

	assign min_votes = min_votes_q;
	assign tol_floor = tol_floor_q;
endmodule

>>> design/mavf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavf_ctrl: sequencing controller
// Steps one detection through count, median search, vote and divide.
// ----------------------------------------------------------------------------
module mavf_ctrl #(
	parameter int HISTORY_DEPTH = mavf_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	output logic                             out_valid,
	input  logic                             out_ready,
	output mavf_pkg::cmd_t                   cmd,
	output logic [$clog2(HISTORY_DEPTH)-1:0] idx
);
	localparam int IDX_W = $clog2(HISTORY_DEPTH);
	localparam int SUM_W = mavf_pkg::sum_width(HISTORY_DEPTH);
	localparam int MAXC  = (HISTORY_DEPTH > SUM_W) ? HISTORY_DEPTH : SUM_W;
	localparam int CNT_W = $clog2(MAXC);
	localparam logic [CNT_W-1:0] LAST_ENTRY = CNT_W'(HISTORY_DEPTH - 1);
	localparam logic [CNT_W-1:0] LAST_BIT   = CNT_W'(SUM_W - 1);

	mavf_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mavf_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd         = '0;
		in_ready    = 1'b0;
		out_valid_d = out_valid_q && !out_ready;
		case (state_q)
			mavf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = mavf_pkg::ST_COUNT;
				end
			end
			mavf_pkg::ST_COUNT: begin
				cmd.count = 1'b1;
				cnt_d     = '0;
				state_d   = mavf_pkg::ST_MEDIAN;
			end
			mavf_pkg::ST_MEDIAN: begin
				cmd.med_step = 1'b1;
				if (cnt_q == LAST_ENTRY) begin
					cnt_d   = '0;
					state_d = mavf_pkg::ST_AGREE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			mavf_pkg::ST_AGREE: begin
				cmd.agr_step = 1'b1;
				if (cnt_q == LAST_ENTRY) begin
					cnt_d   = '0;
					state_d = mavf_pkg::ST_PREP;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			mavf_pkg::ST_PREP: begin
				cmd.div_init = 1'b1;
				cnt_d        = '0;
				state_d      = mavf_pkg::ST_DIVIDE;
			end
			mavf_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (cnt_q == LAST_BIT) begin
					cnt_d   = '0;
					state_d = mavf_pkg::ST_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			mavf_pkg::ST_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = mavf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mavf_pkg::ST_IDLE;
			end
		endcase
	end

	assign idx       = cnt_q[IDX_W-1:0];
	assign out_valid = out_valid_q;
endmodule

>>> design/mavf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavf_dp: vote datapath
// History ring, rank search for the median, agreement vote and divider.
// ----------------------------------------------------------------------------
module mavf_dp #(
	parameter int HISTORY_DEPTH = mavf_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mavf_pkg::cmd_t                   cmd,
	input  logic [$clog2(HISTORY_DEPTH)-1:0] idx,
	input  mavf_pkg::det_item_t              det,
	input  logic [mavf_pkg::VOTE_W-1:0]      min_votes,
	input  logic [mavf_pkg::TOL_W-1:0]       tol_floor,
	output mavf_pkg::res_item_t              res
);
	localparam int D      = HISTORY_DEPTH;
	localparam int IDX_W  = $clog2(D);
	localparam int FILL_W = $clog2(D + 1);
	localparam int SUM_W  = mavf_pkg::sum_width(D);
	localparam int VAL_W  = mavf_pkg::VAL_W;
	localparam int CONF_W = mavf_pkg::CONF_W;
	localparam int SCL_W  = VAL_W + 6;

	logic [VAL_W-1:0]  val_q  [D];
	logic [CONF_W-1:0] conf_q [D];
	logic [IDX_W-1:0]  slot_q;
	logic [FILL_W-1:0] fill_q;

	logic [FILL_W-1:0] n_q, agr_q, rem_q;
	logic [VAL_W-1:0]  med_q;
	logic [SUM_W-1:0]  sum_q, quo_q;
	logic [VAL_W-1:0]  res_val_q;
	logic [CONF_W-1:0] res_conf_q;

	logic [IDX_W-1:0]  wr_slot;
	logic [FILL_W-1:0] wr_fill;
	logic [D-1:0]      vnz, lt, le;
	logic [VAL_W-1:0]  cand, delta;
	logic [FILL_W-1:0] less, leq, half;
	logic [SCL_W-1:0]  scaled;
	logic              agrees, hit;
	logic [FILL_W:0]   trial;
	logic              ok;

	function automatic logic [FILL_W-1:0] ones(input logic [D-1:0] b);
		logic [FILL_W-1:0] c;
		c = '0;
		for (int k = 0; k < D; k++) begin
			c = c + FILL_W'(b[k]);
		end
		return c;
	endfunction

	// restart empties the history before the write
	assign wr_slot = det.restart ? '0 : slot_q;
	assign wr_fill = det.restart ? '0 : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
		end else if (cmd.load) begin
			slot_q <= (wr_slot == IDX_W'(D - 1)) ? '0 : wr_slot + 1'b1;
			fill_q <= (wr_fill == FILL_W'(D)) ? wr_fill : wr_fill + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q[wr_slot]  <= det.detect_value;
			conf_q[wr_slot] <= det.detect_conf;
		end
	end

	// per-slot flags: filled and nonzero, below and not above the candidate
	assign cand = val_q[idx];
	always_comb begin
		for (int k = 0; k < D; k++) begin
			vnz[k] = (FILL_W'(k) < fill_q) && (val_q[k] != '0);
			lt[k]  = vnz[k] && (val_q[k] < cand);
			le[k]  = vnz[k] && (val_q[k] <= cand);
		end
	end

	assign less = ones(lt);
	assign leq  = ones(le);
	assign half = n_q >> 1;
	assign hit  = vnz[idx] && (less <= half) && (half < leq);

	assign delta  = (cand > med_q) ? cand - med_q : med_q - cand;
	assign scaled = SCL_W'(delta) * SCL_W'(50);
	assign agrees = vnz[idx] &&
		((delta <= VAL_W'(tol_floor)) || (scaled <= SCL_W'(med_q)));

	assign trial = {rem_q, quo_q[SUM_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.count) begin
			n_q   <= ones(vnz);
			sum_q <= '0;
			agr_q <= '0;
		end
		if (cmd.med_step && hit) begin
			med_q <= cand;
		end
		if (cmd.agr_step && agrees) begin
			sum_q <= sum_q + SUM_W'(conf_q[idx]);
			agr_q <= agr_q + 1'b1;
		end
		if (cmd.div_init) begin
			quo_q <= sum_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, agr_q}) begin
				rem_q <= FILL_W'(trial - {1'b0, agr_q});
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[FILL_W-1:0];
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			res_val_q  <= ok ? med_q : '0;
			res_conf_q <= ok ? quo_q[CONF_W-1:0] : '0;
		end
	end

	assign ok = (n_q != '0) && (8'(n_q) >= 8'(min_votes)) && (8'(agr_q) >= 8'(min_votes));

	assign res.consensus_value = res_val_q;
	assign res.consensus_conf  = res_conf_q;
endmodule

>>> design/median_agreement_vote_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_agreement_vote_filter: sliding-window median vote, one axis
// Keeps a short history of detections and reports the agreed median.
// ----------------------------------------------------------------------------
// Usage:
//   detection  - sink channel; each transfer carries restart, detect_value
//                (0 = none) and a Q16 detect_conf.
//   consensus  - source channel; exactly one transfer per detection with the
//                median and the mean confidence of agreeing entries, or 0/0.
//   APB port   - min_votes at byte address 0, tol_floor at 4; write only
//                while the block is idle. pready is tied high.
// Sequence: a detection passes through the median rank search and the vote
//   pass, one history slot a cycle each, then the bit-serial divider for the
//   mean confidence, before its result can be transferred. A new detection is
//   taken only once the previous one is finished; one detection is worked on
//   at a time.
// Reset: clears the write slot, the fill count, the controller and the
//   output valid; registers return to min_votes 3, tol_floor 8.
// Stall: a finished result waits in the output register; the next detection
//   is still taken and worked on, and its result holds until that register
//   frees.
// ----------------------------------------------------------------------------
module median_agreement_vote_filter #(
	parameter int HISTORY_DEPTH = mavf_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [mavf_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [mavf_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [mavf_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	mavf_stream_if.sink                      detection,
	mavf_stream_if.source                    consensus
);
	localparam int IDX_W = $clog2(HISTORY_DEPTH);

	logic [mavf_pkg::VOTE_W-1:0] min_votes;
	logic [mavf_pkg::TOL_W-1:0]  tol_floor;
	mavf_pkg::cmd_t              cmd;
	logic [IDX_W-1:0]            idx;
	mavf_pkg::det_item_t         det;
	mavf_pkg::res_item_t         res;

	// configuration registers
	mavf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.min_votes (min_votes),
		.tol_floor (tol_floor)
	);

	// sequencer: owns both handshakes and the slot counter
	mavf_ctrl #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (detection.valid),
		.in_ready  (detection.ready),
		.out_valid (consensus.valid),
		.out_ready (consensus.ready),
		.cmd       (cmd),
		.idx       (idx)
	);

	assign det = detection.payload;

	// history ring, median search, vote and divider
	mavf_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.idx       (idx),
		.det       (det),
		.min_votes (min_votes),
		.tol_floor (tol_floor),
		.res       (res)
	);

	// drive the result transfer from the output register
	assign consensus.payload = res;
endmodule
